>>> rtl/lzw_compressor_12bit_macros.svh
// assertion helpers used by the top-level rtl
`ifndef LZW_COMPRESSOR_12BIT_MACROS_SVH
`define LZW_COMPRESSOR_12BIT_MACROS_SVH

// same-cycle implication
`define LZWC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LZWC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/lzwc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lzwc_pkg;

  localparam int CODE_BITS_DEF  = 12;
  localparam int HASH_SLOTS_DEF = 5021;
  localparam int HASH_MULT      = 92871;
  localparam int FIRST_CODE     = 256;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_PROBE,
    ST_EMIT,
    ST_FIN_PREFIX,
    ST_FIN_END,
    ST_FIN_ZERO
  } lzwc_state_t;

  // code request from the controller to the bit packer
  typedef struct packed {
    logic vld;
    logic fin;
  } pk_ctl_t;

endpackage

`default_nettype wire

>>> rtl/lzwc_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface lzwc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface lzwc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

`default_nettype wire

>>> rtl/lzw_compressor_12bit.sv
`timescale 1ns / 1ps
`default_nettype none
`include "lzw_compressor_12bit_macros.svh"

// LZW compressor with fixed CODE_BITS-wide codes packed msb first into bytes.
// One byte enters per accepted word, with in_last on the final byte of a
// stream; the block emits a code each time the current prefix plus the byte
// is not in the dictionary, and at stream end emits the final prefix, the
// all-ones end code and a zero code, marking the last output word with
// out_last and dropping leftover bits. From one accepted word to the next, a
// byte found at its first probe goes through these steps: accepting it and
// forming the product, the reciprocal quotient, the remainder, the final
// correction with the slot read, and the check of the read entry. Each extra
// probe adds another slot read and check, and a code that goes out adds a
// wait in the emit state until the packer takes it. The first byte of a
// stream only opens the prefix, and the three closing codes each wait until
// the packer has room. After reset and after every stream end all HASH_SLOTS
// slots (5021 at default) are swept clear, and no byte is accepted meanwhile.
module lzw_compressor_12bit #(
  parameter int CODE_BITS  = lzwc_pkg::CODE_BITS_DEF,
  parameter int HASH_SLOTS = lzwc_pkg::HASH_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  lzwc_in_if.sink     in_ch,
  lzwc_out_if.source  out_ch
);
  import lzwc_pkg::*;

  localparam int HW = $clog2(HASH_SLOTS);
  localparam int TW = $clog2(HASH_SLOTS);
  localparam int EW = 2 * CODE_BITS + 8;
  localparam logic [CODE_BITS-1:0] END_CODE = {CODE_BITS{1'b1}};
  localparam logic [CODE_BITS-1:0] FIRST    = CODE_BITS'(FIRST_CODE);

  // controller state
  lzwc_state_t          state_r, state_nxt;
  logic                 have_r, have_nxt;
  logic [CODE_BITS-1:0] prefix_r, prefix_nxt;
  logic [CODE_BITS-1:0] nfc_r, nfc_nxt;       // next free code
  logic [HW-1:0]        clr_r, clr_nxt;       // clearing sweep address
  logic [HW-1:0]        label_r, label_nxt;   // slot under probe
  logic [TW-1:0]        tries_r, tries_nxt;
  logic [7:0]           byte_r, byte_nxt;
  logic                 last_r, last_nxt;

  // hash unit
  logic                 hs_start;
  logic                 hs_done;
  logic [HW-1:0]        hs_label;

  // slot memory, entry is {code, key prefix, key byte}
  logic                 mem_we;
  logic [HW-1:0]        mem_wa;
  logic [EW-1:0]        mem_wd;
  logic                 mem_re;
  logic [HW-1:0]        mem_ra;
  logic [EW-1:0]        mem_rd;

  logic [CODE_BITS-1:0] rd_code;
  logic [CODE_BITS-1:0] rd_pref;
  logic [7:0]           rd_byte;
  logic                 slot_empty;
  logic                 slot_hit;
  logic [HW:0]          step_sum;
  logic [HW-1:0]        nxt_label;

  // packer request
  pk_ctl_t              pk_ctl;
  logic [CODE_BITS-1:0] pk_code;
  logic                 pk_rdy;

  logic                 in_fire;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign rd_code    = mem_rd[EW-1 -: CODE_BITS];
  assign rd_pref    = mem_rd[CODE_BITS+7:8];
  assign rd_byte    = mem_rd[7:0];
  assign slot_empty = (rd_code == '0);
  assign slot_hit   = !slot_empty && (rd_pref == prefix_r) && (rd_byte == byte_r);

  // forward probe step by byte+1, sum stays below twice the slot count
  always_comb begin
    step_sum = (HW+1)'(label_r) + (HW+1)'(byte_r) + (HW+1)'(1);
    if (step_sum >= (HW+1)'(HASH_SLOTS)) begin
      step_sum = step_sum - (HW+1)'(HASH_SLOTS);
    end
    nxt_label = step_sum[HW-1:0];
  end

  lzwc_hash #(
    .CODE_BITS  (CODE_BITS),
    .HASH_SLOTS (HASH_SLOTS)
  ) u_hash (
    .clk      (clk),
    .rst_n    (rst_n),
    .start_i  (hs_start),
    .prefix_i (prefix_r),
    .byte_i   (in_ch.in_byte),
    .done_o   (hs_done),
    .label_o  (hs_label)
  );

  lzwc_dict #(
    .CODE_BITS  (CODE_BITS),
    .HASH_SLOTS (HASH_SLOTS)
  ) u_dict (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_wa),
    .wr_data (mem_wd),
    .rd_en   (mem_re),
    .rd_addr (mem_ra),
    .rd_data (mem_rd)
  );

  lzwc_packer #(
    .CODE_BITS (CODE_BITS)
  ) u_packer (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl_i   (pk_ctl),
    .code_i  (pk_code),
    .ready_o (pk_rdy),
    .out_ch  (out_ch)
  );

  // next state and control; a slot is only written while no read of it is
  // in flight, so the memory needs no forwarding path
  always_comb begin
    state_nxt  = state_r;
    have_nxt   = have_r;
    prefix_nxt = prefix_r;
    nfc_nxt    = nfc_r;
    clr_nxt    = clr_r;
    label_nxt  = label_r;
    tries_nxt  = tries_r;
    byte_nxt   = byte_r;
    last_nxt   = last_r;
    hs_start   = 1'b0;
    mem_we     = 1'b0;
    mem_wa     = label_r;
    mem_wd     = {nfc_r, prefix_r, byte_r};
    mem_re     = 1'b0;
    mem_ra     = nxt_label;
    pk_ctl     = '0;
    pk_code    = prefix_r;

    case (state_r)
      ST_CLEAR: begin
        mem_we  = 1'b1;
        mem_wa  = clr_r;
        mem_wd  = '0;
        clr_nxt = clr_r + HW'(1);
        if (clr_r == HW'(HASH_SLOTS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_fire) begin
          byte_nxt = in_ch.in_byte;
          last_nxt = in_ch.in_last;
          if (!have_r) begin
            // first byte of a stream only opens the prefix
            prefix_nxt = CODE_BITS'(in_ch.in_byte);
            have_nxt   = 1'b1;
            state_nxt  = in_ch.in_last ? ST_FIN_PREFIX : ST_IDLE;
          end else begin
            hs_start  = 1'b1;
            state_nxt = ST_HASH;
          end
        end
      end

      ST_HASH: begin
        if (hs_done) begin
          mem_re    = 1'b1;
          mem_ra    = hs_label;
          label_nxt = hs_label;
          tries_nxt = '0;
          state_nxt = ST_PROBE;
        end
      end

      ST_PROBE: begin
        if (slot_hit) begin
          prefix_nxt = rd_code;
          state_nxt  = last_r ? ST_FIN_PREFIX : ST_IDLE;
        end else if (slot_empty) begin
          // insert unless the dictionary is frozen
          if (nfc_r != END_CODE) begin
            mem_we  = 1'b1;
            nfc_nxt = nfc_r + CODE_BITS'(1);
          end
          state_nxt = ST_EMIT;
        end else if (tries_r == TW'(HASH_SLOTS - 1)) begin
          // every slot probed: a miss with no insert
          state_nxt = ST_EMIT;
        end else begin
          mem_re    = 1'b1;
          label_nxt = nxt_label;
          tries_nxt = tries_r + TW'(1);
        end
      end

      ST_EMIT: begin
        pk_ctl.vld = 1'b1;
        if (pk_rdy) begin
          prefix_nxt = CODE_BITS'(byte_r);
          state_nxt  = last_r ? ST_FIN_PREFIX : ST_IDLE;
        end
      end

      ST_FIN_PREFIX: begin
        pk_ctl.vld = 1'b1;
        if (pk_rdy) begin
          state_nxt = ST_FIN_END;
        end
      end

      ST_FIN_END: begin
        pk_ctl.vld = 1'b1;
        pk_code    = END_CODE;
        if (pk_rdy) begin
          state_nxt = ST_FIN_ZERO;
        end
      end

      ST_FIN_ZERO: begin
        pk_ctl.vld = 1'b1;
        pk_ctl.fin = 1'b1;
        pk_code    = '0;
        if (pk_rdy) begin
          // back to reset state, then sweep the slots
          have_nxt   = 1'b0;
          prefix_nxt = '0;
          nfc_nxt    = FIRST;
          clr_nxt    = '0;
          state_nxt  = ST_CLEAR;
        end
      end

      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLEAR;
      have_r   <= 1'b0;
      prefix_r <= '0;
      nfc_r    <= FIRST;
      clr_r    <= '0;
      tries_r  <= '0;
    end else begin
      state_r  <= state_nxt;
      have_r   <= have_nxt;
      prefix_r <= prefix_nxt;
      nfc_r    <= nfc_nxt;
      clr_r    <= clr_nxt;
      tries_r  <= tries_nxt;
    end
  end

  always_ff @(posedge clk) begin
    label_r <= label_nxt;
    byte_r  <= byte_nxt;
    last_r  <= last_nxt;
  end

  // checks
  logic ins_we;
  logic probe_hit;
  logic fin_take;

  assign ins_we    = mem_we && (state_r == ST_PROBE);
  assign probe_hit = (state_r == ST_PROBE) && slot_hit;
  assign fin_take  = (state_r == ST_FIN_ZERO) && pk_rdy;

  `LZWC_ASSERT_IMP(a_no_frozen_insert, clk, rst_n, ins_we, nfc_r != END_CODE, "insert when full")
  `LZWC_ASSERT_IMP(a_hit_code_range, clk, rst_n, probe_hit, rd_code >= FIRST, "bad hit code")
  `LZWC_ASSERT_NXT(a_clear_after_end, clk, rst_n, fin_take, state_r == ST_CLEAR && !have_r, "no clear")

endmodule

`default_nettype wire

>>> rtl/lzwc_hash.sv
`timescale 1ns / 1ps
`default_nettype none

// start slot (prefix*mult + byte) mod slots: product, reciprocal quotient, remainder
module lzwc_hash #(
  parameter int CODE_BITS  = lzwc_pkg::CODE_BITS_DEF,
  parameter int HASH_SLOTS = lzwc_pkg::HASH_SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start_i,
  input  logic [CODE_BITS-1:0]          prefix_i,
  input  logic [7:0]                    byte_i,
  output logic                          done_o,
  output logic [$clog2(HASH_SLOTS)-1:0] label_o
);
  import lzwc_pkg::*;

  localparam int     HW    = $clog2(HASH_SLOTS);
  localparam int     XW    = CODE_BITS + HW + 1;
  localparam int     KM    = HASH_MULT % HASH_SLOTS;
  localparam longint RECIP = (longint'(1) << XW) / longint'(HASH_SLOTS);
  localparam int     RW    = $clog2(RECIP + 1);
  localparam int     QW    = XW - HW + 1;
  localparam int     PW    = XW + RW;

  logic          v1_r;
  logic          v2_r;
  logic          v3_r;
  logic [XW-1:0] x_r;
  logic [QW-1:0] q_r;
  logic [HW:0]   rem_r;

  logic [PW-1:0] q_prod;
  logic [HW:0]   rem_fix;

  // quotient estimate is at most one short, so one subtract finishes
  assign q_prod  = PW'(x_r) * PW'(RECIP);
  assign rem_fix = (rem_r >= (HW+1)'(HASH_SLOTS)) ? rem_r - (HW+1)'(HASH_SLOTS) : rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= start_i;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start_i) begin
      x_r <= XW'(prefix_i) * XW'(KM) + XW'(byte_i);
    end
    if (v1_r) begin
      q_r <= QW'(q_prod >> XW);
    end
    if (v2_r) begin
      rem_r <= (HW+1)'(x_r - XW'(q_r) * XW'(HASH_SLOTS));
    end
  end

  assign done_o  = v3_r;
  assign label_o = rem_fix[HW-1:0];

endmodule

`default_nettype wire

>>> rtl/lzwc_dict.sv
`timescale 1ns / 1ps
`default_nettype none

// slot memory, one write and one registered read per cycle
module lzwc_dict #(
  parameter int CODE_BITS  = lzwc_pkg::CODE_BITS_DEF,
  parameter int HASH_SLOTS = lzwc_pkg::HASH_SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [$clog2(HASH_SLOTS)-1:0] wr_addr,
  input  logic [2*CODE_BITS+7:0]        wr_data,
  input  logic                          rd_en,
  input  logic [$clog2(HASH_SLOTS)-1:0] rd_addr,
  output logic [2*CODE_BITS+7:0]        rd_data
);
  import lzwc_pkg::*;

  localparam int EW = 2 * CODE_BITS + 8;

  logic [EW-1:0] mem [HASH_SLOTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/lzwc_packer.sv
`timescale 1ns / 1ps
`default_nettype none

// packs codes msb first into bytes, output register toward the sink
module lzwc_packer #(
  parameter int CODE_BITS = lzwc_pkg::CODE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  lzwc_pkg::pk_ctl_t      ctl_i,
  input  logic [CODE_BITS-1:0]   code_i,
  output logic                   ready_o,
  lzwc_out_if.source             out_ch
);
  import lzwc_pkg::*;

  localparam int AW = CODE_BITS + 7;
  localparam int NW = $clog2(CODE_BITS + 8);

  logic [AW-1:0] acc_r;
  logic [NW-1:0] nbits_r;
  logic          fin_r;
  logic          ov_r;
  logic [7:0]    ob_r;
  logic          ol_r;

  logic [NW-1:0] sh;
  logic          slot_free;
  logic          emit;
  logic          take;
  logic          end_word;

  assign sh        = nbits_r - NW'(8);
  assign slot_free = !ov_r || out_ch.ready;
  assign emit      = (nbits_r >= NW'(8)) && slot_free;
  assign ready_o   = (nbits_r < NW'(8));
  assign take      = ctl_i.vld && ready_o;
  assign end_word  = fin_r && (sh < NW'(8));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nbits_r <= '0;
      fin_r   <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      if (take) begin
        nbits_r <= nbits_r + NW'(CODE_BITS);
        fin_r   <= ctl_i.fin;
      end else if (emit) begin
        // leftover bits after the closing word are dropped
        nbits_r <= end_word ? '0 : sh;
        if (end_word) begin
          fin_r <= 1'b0;
        end
      end
      if (emit) begin
        ov_r <= 1'b1;
      end else if (out_ch.ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      acc_r <= {acc_r[6:0], code_i};
    end
    if (emit) begin
      ob_r <= 8'(acc_r >> sh);
      ol_r <= end_word;
    end
  end

  assign out_ch.valid    = ov_r;
  assign out_ch.out_byte = ob_r;
  assign out_ch.out_last = ol_r;

endmodule

`default_nettype wire
